/* sv/sts_pkg.sv */
// Shared types, widths and codes for the sorted timestamp table.
package sts_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DEF_TAG_BITS = 16;

  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned LABEL_W  = 16;
  localparam int unsigned RIDX_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned TOTAL_W  = 32;

  localparam int unsigned S_DATA_W = 88;
  localparam int unsigned M_DATA_W = 80;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

/* sv/sts_cell.sv */
// One table slot: holds a stamp and tag, compares and shifts with its neighbors.
module sts_cell
  import sts_pkg::*;
#(
  parameter int unsigned IDX      = 0,
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned TAG_BITS = DEF_TAG_BITS,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [CNT_W-1:0]    fill_i,
  input  logic [RIDX_W-1:0]   rm_idx_i,
  input  logic [STAMP_W-1:0]  cmp_stamp_i,
  input  logic [STAMP_W-1:0]  new_stamp_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                prev_lt_i,
  input  logic [STAMP_W-1:0]  prev_stamp_i,
  input  logic [TAG_BITS-1:0] prev_tag_i,
  input  logic [STAMP_W-1:0]  next_stamp_i,
  input  logic [TAG_BITS-1:0] next_tag_i,
  output logic                lt_o,
  output logic                sel_o,
  output logic [STAMP_W-1:0]  stamp_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic                lt_q, lt_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                occupied;
  logic                pull_next;

  assign occupied  = 32'(IDX) < 32'(fill_i);
  assign pull_next = (32'(IDX) >= 32'(rm_idx_i)) && (IDX + 1 < CAPACITY);
  assign sel_o     = !lt_q && prev_lt_i;

  always_comb begin
    lt_d    = lt_q;
    stamp_d = stamp_q;
    tag_d   = tag_q;
    if (ctrl_i.capture) begin
      lt_d = occupied && ($signed(stamp_q) < $signed(cmp_stamp_i));
    end
    if (ctrl_i.insert && !lt_q) begin
      if (prev_lt_i) begin
        stamp_d = new_stamp_i;
        tag_d   = new_tag_i;
      end else begin
        stamp_d = prev_stamp_i;
        tag_d   = prev_tag_i;
      end
    end else if (ctrl_i.remove && pull_next) begin
      stamp_d = next_stamp_i;
      tag_d   = next_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    tag_q   <= tag_d;
  end

  assign lt_o    = lt_q;
  assign stamp_o = stamp_q;
  assign tag_o   = tag_q;

endmodule

/* sv/sts_encoder.sv */
// One-hot to binary encoder for the insert slot.
module sts_encoder
  import sts_pkg::*;
#(
  parameter int unsigned N = DEF_CAPACITY,
  parameter int unsigned W = $clog2(N)
) (
  input  logic [N-1:0] onehot_i,
  output logic [W-1:0] index_o
);

  always_comb begin
    index_o = '0;
    for (int unsigned b = 0; b < W; b++) begin
      for (int unsigned i = 0; i < N; i++) begin
        if (((i >> b) & 1) == 1) begin
          index_o[b] = index_o[b] | onehot_i[i];
        end
      end
    end
  end

endmodule

/* sv/sorted_timestamp_table.sv */
// Top level of the sorted timestamp table: control, counters and the cell row.
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid/tready_o      tuser: action; tdata: stamp, label_tag, remove_index
//  m_axis   out  m_axis_tvalid_o/tready_i    tuser: status; tdata: position, entry_count, totals
//
// A remove, a dropped insert and an ignored remove register their result when
// accepted; an insert first has the row compare every slot against the new
// stamp, then shifts in the busy state. Reset clears counts and control; slot contents
// are undefined until written. A waiting result blocks the input until it is
// taken, so the next item can enter in that same cycle; a stalled output holds
// an insert in its shift cycle.
module sorted_timestamp_table
  import sts_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned TAG_BITS = DEF_TAG_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,  // stamp, label_tag, remove_index
  input  logic                s_axis_tuser_i,  // action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,  // position, entry_count, added_total,
                                               // removed_total, zero pad
  output logic [STATUS_W-1:0] m_axis_tuser_o   // status
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic [STAMP_W-1:0]  in_stamp;
  logic [LABEL_W-1:0]  in_label;
  logic [RIDX_W-1:0]   in_ridx;
  logic [TAG_BITS-1:0] in_tag;

  assign in_stamp = s_axis_tdata_i[STAMP_W-1:0];
  assign in_label = s_axis_tdata_i[STAMP_W+LABEL_W-1:STAMP_W];
  assign in_ridx  = s_axis_tdata_i[STAMP_W+LABEL_W+RIDX_W-1:STAMP_W+LABEL_W];

  if (TAG_BITS > LABEL_W) begin : g_tag_wide
    assign in_tag = TAG_BITS'(in_label);
  end else begin : g_tag_narrow
    assign in_tag = in_label[TAG_BITS-1:0];
  end

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [TOTAL_W-1:0]  add_q, add_d;
  logic [TOTAL_W-1:0]  rem_q, rem_d;
  logic [STAMP_W-1:0]  hold_stamp_q;
  logic [TAG_BITS-1:0] hold_tag_q;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic [TOTAL_W-1:0]  out_add_q, out_add_d;
  logic [TOTAL_W-1:0]  out_rem_q, out_rem_d;

  logic       out_free, in_fire, full, bad_idx, load;
  cell_ctrl_t ctrl;

  logic [CAPACITY-1:0] lt, sel;
  logic [STAMP_W-1:0]  stamps [CAPACITY];
  logic [TAG_BITS-1:0] tags   [CAPACITY];
  logic [IDX_W-1:0]    ins_idx;
  logic [31:0]         ins_pos_ext, rm_pos_ext;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !busy_q && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = 32'(fill_q) == 32'(CAPACITY);
  assign bad_idx         = 32'(in_ridx) >= 32'(fill_q);
  assign ins_pos_ext     = 32'(ins_idx);
  assign rm_pos_ext      = 32'(in_ridx);

  always_comb begin
    ctrl         = '0;
    busy_d       = busy_q;
    fill_d       = fill_q;
    add_d        = add_q;
    rem_d        = rem_q;
    load         = 1'b0;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    if (busy_q) begin
      if (out_free) begin
        ctrl.insert  = 1'b1;
        busy_d       = 1'b0;
        fill_d       = fill_q + CNT_W'(1);
        add_d        = add_q + TOTAL_W'(1);
        load         = 1'b1;
        out_status_d = ST_INSERTED;
        out_pos_d    = ins_pos_ext[POS_W-1:0];
      end
    end else if (in_fire) begin
      load = 1'b1;
      if (s_axis_tuser_i == ACT_INSERT) begin
        if (full) begin
          out_status_d = ST_FULL;
          out_pos_d    = '0;
        end else begin
          ctrl.capture = 1'b1;
          busy_d       = 1'b1;
          load         = 1'b0;
        end
      end else begin
        if (bad_idx) begin
          out_status_d = ST_BAD_IDX;
          out_pos_d    = '0;
        end else begin
          ctrl.remove  = 1'b1;
          fill_d       = fill_q - CNT_W'(1);
          rem_d        = rem_q + TOTAL_W'(1);
          out_status_d = ST_REMOVED;
          out_pos_d    = rm_pos_ext[POS_W-1:0];
        end
      end
    end
    out_valid_d = load || (out_valid_q && !m_axis_tready_i);
    out_count_d = load ? COUNT_W'(fill_d) : out_count_q;
    out_add_d   = load ? add_d : out_add_q;
    out_rem_d   = load ? rem_d : out_rem_q;
    if (!load) begin
      out_status_d = out_status_q;
      out_pos_d    = out_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fill_q      <= '0;
      add_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      fill_q      <= fill_d;
      add_q       <= add_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      hold_stamp_q <= in_stamp;
      hold_tag_q   <= in_tag;
    end
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
    out_add_q    <= out_add_d;
    out_rem_q    <= out_rem_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                prev_lt;
    logic [STAMP_W-1:0]  prev_stamp, next_stamp;
    logic [TAG_BITS-1:0] prev_tag, next_tag;

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_stamp = '0;
      assign prev_tag   = '0;
    end else begin : g_mid
      assign prev_lt    = lt[i-1];
      assign prev_stamp = stamps[i-1];
      assign prev_tag   = tags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_stamp = '0;
      assign next_tag   = '0;
    end else begin : g_inner
      assign next_stamp = stamps[i+1];
      assign next_tag   = tags[i+1];
    end

    sts_cell #(
      .IDX      (i),
      .CAPACITY (CAPACITY),
      .TAG_BITS (TAG_BITS),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .fill_i       (fill_q),
      .rm_idx_i     (in_ridx),
      .cmp_stamp_i  (in_stamp),
      .new_stamp_i  (hold_stamp_q),
      .new_tag_i    (hold_tag_q),
      .prev_lt_i    (prev_lt),
      .prev_stamp_i (prev_stamp),
      .prev_tag_i   (prev_tag),
      .next_stamp_i (next_stamp),
      .next_tag_i   (next_tag),
      .lt_o         (lt[i]),
      .sel_o        (sel[i]),
      .stamp_o      (stamps[i]),
      .tag_o        (tags[i])
    );
  end

  sts_encoder #(
    .N (CAPACITY),
    .W (IDX_W)
  ) u_enc (
    .onehot_i (sel),
    .index_o  (ins_idx)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_rem_q, out_add_q, out_count_q, out_pos_q};

endmodule
